>>> rtl/layer_alpha_merge_macros.svh
// Assertion macros shared by the layer merge checker.
`ifndef LAYER_ALPHA_MERGE_MACROS_SVH
`define LAYER_ALPHA_MERGE_MACROS_SVH
`define LAM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LAM_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/lam_pkg.sv
// Package with widths, register indexes and helpers for the layer merge block.
package lam_pkg;
	localparam int ByteW = 8;
	localparam int OpW = 16;
	localparam int AlphaW = 17;
	localparam int IdxW = 1;
	localparam logic [OpW-1:0] OpOne = 16'd32768;
	localparam logic [IdxW-1:0] RegBottomOp = 1'd0;
	localparam logic [IdxW-1:0] RegTopOp = 1'd1;
	localparam int DivSteps = 17;
	localparam int StepsPerStage = 3;
	localparam int DivStages = (DivSteps + StepsPerStage - 1) / StepsPerStage;
	localparam int DefPipeStages = DivStages + 4;

	// One restoring division step: shift in a bit, compare, subtract.
	typedef struct packed {
		logic [17:0] rem;
		logic [33:0] num;
		logic [16:0] quo;
	} div_t;

	function automatic div_t div_step(input div_t s, input logic [16:0] d);
		logic [18:0] r;
		div_t o;
		r = {s.rem, s.num[33]};
		o.num = {s.num[32:0], 1'b0};
		if (r >= {2'b00, d}) begin
			o.rem = 18'(r - {2'b00, d});
			o.quo = {s.quo[15:0], 1'b1};
		end else begin
			o.rem = r[17:0];
			o.quo = {s.quo[15:0], 1'b0};
		end
		return o;
	endfunction
endpackage

>>> rtl/layer_alpha_merge.sv
// Top level of the layer merge: a pipelined non-premultiplied "over" compositor.
// Usage:
//  - s_axis carries one bottom/top pixel pair per request; m_axis returns one
//    merged pixel per request, in order.
//  - cfg writes the two layer opacities (index 0 bottom, 1 top), Q15 with
//    32768 fully opaque; larger values act as 32768. Write only while idle.
//  - Throughput is one pixel per clock while m_axis_tready does not stall the
//    output. Three stages form the alphas, the product and the combined alpha,
//    six stages run the two weight divisions at up to three quotient bits per
//    stage, one stage blends.
//  - The whole pipeline advances only when its last stage is empty or taken,
//    so a stalled receiver holds every stage; nothing is lost or repeated.
//  - Reset clears all valid bits and sets both opacities to fully opaque.
module layer_alpha_merge
	import lam_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// bottom_c0, bottom_c1, bottom_c2, bottom_alpha, top_c0, top_c1, top_c2, top_alpha
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_c0, out_c1, out_c2, out_alpha
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic [OpW-1:0] bop_q, top_q;
	logic adv;
	logic [DefPipeStages-1:0] v_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bop_q <= OpOne;
			top_q <= OpOne;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegBottomOp: bop_q <= cfg_data;
				RegTopOp: top_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv = !v_q[DefPipeStages-1] || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = v_q[DefPipeStages-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[DefPipeStages-2:0], s_axis_tvalid};
	end

	// Stage 1: clamp opacities, multiply alpha byte by opacity.
	logic [47:0] col_s1;
	logic [23:0] pa_s1, pb_s1;
	logic [OpW-1:0] ob, ot;
	assign ob = (bop_q > OpOne) ? OpOne : bop_q;
	assign ot = (top_q > OpOne) ? OpOne : top_q;
	always_ff @(posedge clk) if (adv) begin
		col_s1 <= {s_axis_tdata[55:32], s_axis_tdata[23:0]};
		pa_s1 <= 24'(s_axis_tdata[31:24] * ob);
		pb_s1 <= 24'(s_axis_tdata[63:56] * ot);
	end

	// Stage 2: divide 2*x by 255 via reciprocal and one correction.
	function automatic logic [AlphaW-1:0] div255(input logic [24:0] x);
		logic [50:0] q;
		logic [24:0] r;
		q = 51'(x) * 51'd131586;
		r = 25'(x - 25'(q[50:25]) * 25'd255);
		return (r >= 25'd255) ? AlphaW'(q[50:25] + 26'd1) : AlphaW'(q[50:25]);
	endfunction
	logic [47:0] col_s2;
	logic [AlphaW-1:0] a_s2, b_s2;
	always_ff @(posedge clk) if (adv) begin
		col_s2 <= col_s1;
		a_s2 <= div255({pa_s1, 1'b0});
		b_s2 <= div255({pb_s1, 1'b0});
	end

	// Stage 3: product and combined alpha.
	logic [47:0] col_s3;
	logic [AlphaW-1:0] ap_s3, b_s3, n_s3;
	logic [33:0] ab;
	logic [AlphaW-1:0] p;
	assign ab = a_s2 * b_s2;
	assign p = AlphaW'(ab >> 16);
	always_ff @(posedge clk) if (adv) begin
		col_s3 <= col_s2;
		ap_s3 <= a_s2 - p;
		b_s3 <= b_s2;
		n_s3 <= 17'(18'(a_s2) + 18'(b_s2) - 18'(p));
	end

	// Division stages: both weights share the divisor n.
	// The dividend is x * 65536 with x <= n, so its upper bits x >> 1 start as
	// the remainder and only the last 17 bits need division steps.
	div_t db_q [DivStages+1];
	div_t dt_q [DivStages+1];
	logic [47:0] col_q [DivStages+1];
	logic [AlphaW-1:0] n_q [DivStages+1];
	always_comb begin
		db_q[0] = '{rem: 18'(ap_s3[16:1]), num: {ap_s3[0], 33'd0}, quo: '0};
		dt_q[0] = '{rem: 18'(b_s3[16:1]), num: {b_s3[0], 33'd0}, quo: '0};
		col_q[0] = col_s3;
		n_q[0] = n_s3;
	end
	for (genvar g = 0; g < DivStages; g++) begin : g_div
		div_t nb, nt;
		always_comb begin
			nb = db_q[g];
			nt = dt_q[g];
			for (int k = 0; k < StepsPerStage; k++) begin
				if (g * StepsPerStage + k < DivSteps) begin
					nb = div_step(nb, n_q[g]);
					nt = div_step(nt, n_q[g]);
				end
			end
		end
		always_ff @(posedge clk) if (adv) begin
			db_q[g+1] <= nb;
			dt_q[g+1] <= nt;
			col_q[g+1] <= col_q[g];
			n_q[g+1] <= n_q[g];
		end
	end

	// Last stage: blend and saturate the colours, form the output alpha.
	logic [AlphaW-1:0] wb, wt;
	logic [AlphaW-1:0] nf;
	logic [47:0] cf;
	logic [31:0] res;
	logic [24:0] na;
	assign nf = n_q[DivStages];
	assign cf = col_q[DivStages];
	assign wb = (nf == '0) ? 17'd32768 : db_q[DivStages].quo;
	assign wt = (nf == '0) ? 17'd32768 : dt_q[DivStages].quo;
	assign na = 25'(nf) * 25'd255;
	always_comb begin
		logic [25:0] s;
		res = '0;
		for (int i = 0; i < 3; i++) begin
			s = 26'(wb * cf[8*i +: 8]) + 26'(wt * cf[24+8*i +: 8]);
			res[8*i +: 8] = (s[25:16] > 10'd255) ? 8'd255 : s[23:16];
		end
		res[31:24] = na[23:16];
	end
	logic [31:0] out_q;
	always_ff @(posedge clk) if (adv) out_q <= res;
	assign m_axis_tdata = out_q;
endmodule

>>> rtl/lam_checker.sv
// Port-level checker for the layer merge, bound to the top level.
`include "layer_alpha_merge_macros.svh"
module lam_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic cfg_ready
);
	`LAM_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
	`LAM_ASSERT(a_ready, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while pipeline stalled")
	`LAM_ASSERT(a_free, !m_axis_tvalid |-> s_axis_tready, "input refused with empty output")
	`LAM_ASSERT_RST(a_rst, !arst_n |=> !m_axis_tvalid, "output valid after reset")
	`LAM_ASSERT(a_cfg, cfg_ready, "config port not ready")
endmodule

bind layer_alpha_merge lam_checker u_lam_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .cfg_ready(cfg_ready)
);

>>> test/layer_alpha_merge_tb.sv
// Testbench for layer_alpha_merge: directed and random pixel pairs checked against a predictor.
`timescale 1ns / 1ps

module layer_alpha_merge_tb;
	import lam_pkg::*;

	typedef struct {
		logic [63:0] pix;
		bit          known;
		logic [31:0] merged;
	} pix_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// bottom_c0, bottom_c1, bottom_c2, bottom_alpha, top_c0, top_c1, top_c2, top_alpha
	logic [63:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// out_c0, out_c1, out_c2, out_alpha
	logic [31:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;

	logic [OpW-1:0] bottom_op;
	logic [OpW-1:0] top_op;
	logic [31:0]    merged_q[$];
	int             fails;
	int             send_idle_pct;
	int             recv_stall_pct;
	bit             hold_req;
	int             hold_left;
	bit             row_known;
	logic [31:0]    row_merged;

	// Expected results are typed only where they follow at a glance.
	pix_row_t dir_rows[10] = '{
		'{64'h0000000000000000, 1'b1, 32'h00000000},
		'{64'h00000000_00ffffff, 1'b1, 32'h007f7f7f},
		'{64'hffccbbaa_50563412, 1'b1, 32'hffccbbaa},
		'{64'h00778899_ff332211, 1'b1, 32'hff332211},
		'{64'hffffffff_ffffffff, 1'b1, 32'hffffffff},
		'{64'h00ffffff_ff000000, 1'b1, 32'hff000000},
		'{64'h80ffffff_80000000, 1'b0, 32'h0},
		'{64'h01102030_fe405060, 1'b0, 32'h0},
		'{64'hfe0000ff_01ff00ff, 1'b0, 32'h0},
		'{64'h7f123456_40fedcba, 1'b0, 32'h0}
	};

	layer_alpha_merge uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic longint unsigned layer_alpha(logic [7:0] a_byte, logic [OpW-1:0] op);
		longint unsigned o;
		o = (op > OpOne) ? OpOne : op;
		return (a_byte * o * 2) / 255;
	endfunction

	function automatic logic [31:0] merge_pixel(logic [63:0] pix);
		longint unsigned a, b, p, n, wb, wt, v;
		logic [31:0] r;
		a = layer_alpha(pix[31:24], bottom_op);
		b = layer_alpha(pix[63:56], top_op);
		p = (a * b) >> 16;
		n = a + b - p;
		if (n > 0) begin
			wb = ((a - p) << 16) / n;
			wt = (b << 16) / n;
		end else begin
			wb = 32768;
			wt = 32768;
		end
		for (int i = 0; i < 3; i++) begin
			v = (pix[8*i +: 8] * wb + pix[32 + 8*i +: 8] * wt) >> 16;
			r[8*i +: 8] = (v > 255) ? 8'hff : v[7:0];
		end
		r[31:24] = 8'((255 * n) >> 16);
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fails++;
	endtask

	// Request and result bookkeeping; both sides are sampled before any update of this edge.
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				merged_q.push_back(row_known ? row_merged : merge_pixel(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (merged_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
				end else begin
					want = merged_q.pop_front();
					for (int i = 0; i < 4; i++)
						if (m_axis_tdata[8*i +: 8] !== want[8*i +: 8])
							report_mismatch($sformatf("field %0d got %h want %h (%h vs %h)",
								i, m_axis_tdata[8*i +: 8], want[8*i +: 8], m_axis_tdata, want));
				end
			end
		end
	end

	// Receiver; a hold request keeps it off for a fixed stretch.
	always @(posedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left <= 300;
			hold_req <= 1'b0;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_pixel(logic [63:0] pix, bit known, logic [31:0] merged);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pix;
		row_known <= known;
		row_merged <= merged;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == RegBottomOp)
			bottom_op = value;
		else
			top_op = value;
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (merged_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_alpha();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	initial begin
		logic [63:0] pix;
		logic [15:0] ops[8][2];
		fails = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		m_axis_tready = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		row_known = 1'b0;
		row_merged = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		bottom_op = OpOne;
		top_op = OpOne;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_pixel(dir_rows[i].pix, dir_rows[i].known, dir_rows[i].merged);
		drain();

		ops = '{'{16'd32768, 16'd32768}, '{16'd0, 16'd0}, '{16'hffff, 16'hffff},
			'{16'd0, 16'd32768}, '{16'd32768, 16'd0}, '{16'd1, 16'd32767},
			'{16'h0, 16'h0}, '{16'h0, 16'h0}};
		ops[6][0] = 16'($urandom_range(32768));
		ops[6][1] = 16'($urandom_range(32768));
		ops[7][0] = 16'($urandom_range(65535));
		ops[7][1] = 16'($urandom_range(65535));

		foreach (ops[ph]) begin
			write_reg(RegBottomOp, ops[ph][0]);
			write_reg(RegTopOp, ops[ph][1]);
			for (int mode = 0; mode < 4; mode++) begin
				send_idle_pct = (mode == 1) ? 83 : (mode == 3) ? 33 : 0;
				recv_stall_pct = (mode == 2) ? 83 : (mode == 3) ? 33 : 0;
				for (int k = 0; k < 58; k++) begin
					if (ph == 2 && mode == 0 && k == 5)
						hold_req <= 1'b1;
					pix = {$urandom, $urandom};
					pix[31:24] = rand_alpha();
					pix[63:56] = rand_alpha();
					send_pixel(pix, 1'b0, 32'h0);
				end
			end
			drain();
		end

		if (fails == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
